@@ design/encoder_turn_and_activity_tracker_macros.svh @@
// assertion macros for the encoder turn and activity tracker
`ifndef ENCODER_TURN_AND_ACTIVITY_TRACKER_MACROS_SVH
`define ENCODER_TURN_AND_ACTIVITY_TRACKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ETAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("etat assertion failed");

// next-cycle implication, checked outside reset
`define ETAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("etat assertion failed");

`endif

@@ design/etat_pkg.sv @@
// shared types and constants of the encoder turn and activity tracker
package etat_pkg;

    // steps per whole turn; the turn split in etat_step_calc is a shift, so this stays a power of two
    localparam int TURN_STEPS     = 8;
    localparam int STEP_BITS      = $clog2(TURN_STEPS);
    localparam int REM_W          = STEP_BITS + 1;
    localparam int POS_W          = 32;
    localparam int TIME_W         = 32;
    localparam int TURNS_W        = 29;
    localparam int COOL_W         = 16;
    localparam int ACC_W          = POS_W + 1;

    localparam logic [COOL_W-1:0] COOLDOWN_RESET = 16'd2000;

    // one poll word
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic              button;
        logic [TIME_W-1:0] now_ms;
    } t_poll;

    // one result word
    typedef struct packed {
        logic signed [TURNS_W-1:0] turns;
        logic                      turns_valid;
        logic                      button_pressed;
        logic                      display_on_event;
        logic                      display_off_event;
    } t_result;

    // tracker state carried from poll to poll
    typedef struct packed {
        logic [POS_W-1:0]        last_position;
        logic signed [REM_W-1:0] step_remainder;
        logic                    touched;
        logic                    cooldown_pending;
        logic [TIME_W-1:0]       release_stamp;
    } t_state;

endpackage

@@ design/etat_poll_if.sv @@
// poll channel: valid/ready handshake with the poll fields
interface etat_poll_if;
    logic                          valid;
    logic                          ready;
    logic [etat_pkg::POS_W-1:0]    position;
    logic                          button;
    logic [etat_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output position, output button, output now_ms, input ready);
    modport sink   (input valid, input position, input button, input now_ms, output ready);
endinterface

@@ design/etat_result_if.sv @@
// result channel: valid/ready handshake with the result fields
interface etat_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [etat_pkg::TURNS_W-1:0] turns;
    logic                                turns_valid;
    logic                                button_pressed;
    logic                                display_on_event;
    logic                                display_off_event;

    modport source (output valid, output turns, output turns_valid, output button_pressed,
                    output display_on_event, output display_off_event, input ready);
    modport sink   (input valid, input turns, input turns_valid, input button_pressed,
                    input display_on_event, input display_off_event, output ready);
endinterface

@@ design/etat_step_calc.sv @@
// per-poll logic: touch tracking, turn split, cooldown timer
module etat_step_calc (
    input  etat_pkg::t_poll                  i_poll,
    input  etat_pkg::t_state                 i_state,
    input  logic [etat_pkg::COOL_W-1:0]      i_cooldown_ms,
    output etat_pkg::t_state                 o_state,
    output etat_pkg::t_result                o_result
);

    localparam int ACC_W   = etat_pkg::ACC_W;
    localparam int POS_W   = etat_pkg::POS_W;
    localparam int REM_W   = etat_pkg::REM_W;
    localparam int TURNS_W = etat_pkg::TURNS_W;
    localparam int TIME_W  = etat_pkg::TIME_W;

    logic [POS_W-1:0]        delta;
    logic                    moved;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-1:0] quot;
    logic signed [ACC_W-1:0] rem_full;
    logic                    sat_hi;
    logic                    sat_lo;
    logic signed [TURNS_W-1:0] turns_sat;
    logic                    touch_mid;
    logic                    began;
    logic                    touched_end;
    logic                    pending_end;
    logic [TIME_W-1:0]       stamp_end;
    logic [TIME_W-1:0]       idle;
    logic                    expired;

    // wrapping delta and accumulated steps
    assign delta = i_poll.position - i_state.last_position;
    assign moved = (delta != '0);
    assign acc   = $signed({delta[POS_W-1], delta})
                 + $signed({{(ACC_W-REM_W){i_state.step_remainder[REM_W-1]}},
                            i_state.step_remainder});

    // divide by steps per turn, truncating toward zero
    assign biased   = acc + (acc[ACC_W-1] ? ACC_W'(etat_pkg::TURN_STEPS - 1) : '0);
    assign quot     = biased >>> etat_pkg::STEP_BITS;
    assign rem_full = acc - (quot <<< etat_pkg::STEP_BITS);

    // clamp to the turns range
    assign sat_hi = !quot[ACC_W-1] && (|quot[ACC_W-2:TURNS_W-1]);
    assign sat_lo = quot[ACC_W-1] && !(&quot[ACC_W-2:TURNS_W-1]);
    always_comb begin
        if (sat_hi) begin
            turns_sat = {1'b0, {(TURNS_W-1){1'b1}}};
        end else if (sat_lo) begin
            turns_sat = {1'b1, {(TURNS_W-1){1'b0}}};
        end else begin
            turns_sat = quot[TURNS_W-1:0];
        end
    end

    // touch and release
    assign touch_mid   = i_state.touched || i_poll.button;
    assign began       = !i_state.touched && (i_poll.button || moved);
    assign touched_end = moved;
    assign stamp_end   = (!moved && touch_mid) ? i_poll.now_ms : i_state.release_stamp;
    assign pending_end = moved ? 1'b0
                       : (touch_mid ? 1'b1 : (i_state.cooldown_pending && !i_poll.button));

    // cooldown timer, wrap-safe
    assign idle    = i_poll.now_ms - stamp_end;
    assign expired = !touched_end && pending_end
                   && (idle >= {{(TIME_W-etat_pkg::COOL_W){1'b0}}, i_cooldown_ms});

    // next state
    always_comb begin
        o_state                  = i_state;
        o_state.touched          = touched_end;
        o_state.cooldown_pending = pending_end && !expired;
        o_state.release_stamp    = stamp_end;
        if (moved) begin
            o_state.last_position  = i_poll.position;
            o_state.step_remainder = rem_full[REM_W-1:0];
        end
    end

    // result word
    always_comb begin
        o_result.turns             = moved ? turns_sat : '0;
        o_result.turns_valid       = moved && (turns_sat != '0);
        o_result.button_pressed    = i_poll.button;
        o_result.display_on_event  = began;
        o_result.display_off_event = expired;
    end

endmodule

@@ design/encoder_turn_and_activity_tracker.sv @@
// top level of the encoder turn and activity tracker
//
//   channel    dir  handshake      word
//   i_poll     in   valid/ready    position, button, now_ms
//   o_result   out  valid/ready    turns, turns_valid, button_pressed, display events
//   i_cfg_*    in   write enable   cooldown_ms
//
// one poll word accepted per cycle unless the result stalls; a poll passes the input register,
// then the one-pass step logic, into the result register
// reset clears the state and both valid flags and sets cooldown_ms to 2000
// a stalled result register holds and the input register stops behind it
`include "encoder_turn_and_activity_tracker_macros.svh"

module encoder_turn_and_activity_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [etat_pkg::COOL_W-1:0]   i_cfg_wdata,
    etat_poll_if.sink                     i_poll,
    etat_result_if.source                 o_result
);

    logic                         r_in_valid;
    etat_pkg::t_poll              r_in;
    logic                         r_out_valid;
    etat_pkg::t_result            r_out;
    etat_pkg::t_state             r_state;
    logic [etat_pkg::COOL_W-1:0]  r_cooldown_ms;
    etat_pkg::t_state             n_state;
    etat_pkg::t_result            n_result;
    logic                         adv;

    // flow control
    assign adv          = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_poll.ready = !r_in_valid || adv;

    // cooldown register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cooldown_ms <= etat_pkg::COOLDOWN_RESET;
        end else if (i_cfg_we) begin
            r_cooldown_ms <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_poll.ready) begin
            r_in_valid <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_poll.ready && i_poll.valid) begin
            r_in.position <= i_poll.position;
            r_in.button   <= i_poll.button;
            r_in.now_ms   <= i_poll.now_ms;
        end
    end

    // step logic
    etat_step_calc u_calc (
        .i_poll        (r_in),
        .i_state       (r_state),
        .i_cooldown_ms (r_cooldown_ms),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_result;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.turns             = r_out.turns;
    assign o_result.turns_valid       = r_out.turns_valid;
    assign o_result.button_pressed    = r_out.button_pressed;
    assign o_result.display_on_event  = r_out.display_on_event;
    assign o_result.display_off_event = r_out.display_off_event;

    // checks
    `ETAT_ASSERT_NOW(a_touch_excludes_cooldown, i_clk, i_rst_n, r_state.touched, !r_state.cooldown_pending)
    `ETAT_ASSERT_NOW(a_remainder_in_range, i_clk, i_rst_n, 1'b1, r_state.step_remainder != {1'b1, {(etat_pkg::REM_W-1){1'b0}}})
    `ETAT_ASSERT_NEXT(a_state_holds_when_idle, i_clk, i_rst_n, !adv, $stable(r_state))

endmodule
